// ----- design/bsa_pkg.sv -----
// bsa_pkg: shared types, codes and row helpers for the banker's-algorithm allocator.
// No dependencies; imported by bsa_lane, bsa_merge and bankers_safe_allocator.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int NRES          = 4;
    localparam int RES_W         = 8;
    localparam int CUSTOMERS_DEF = 8;

    typedef logic [RES_W-1:0]           res_t;
    typedef logic [NRES-1:0][RES_W-1:0] res_row_t;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_LOAD = 2'd1,
        OP_REQ  = 2'd2,
        OP_REL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_NEED   = 3'd1,
        ST_AVAIL  = 3'd2,
        ST_UNSAFE = 3'd3,
        ST_REL    = 3'd4
    } status_t;

    // row write broadcast to all lanes; only the selected lane takes it
    typedef struct packed {
        logic     en;
        res_row_t alloc;
        res_row_t need;
    } row_wr_t;

    typedef struct packed {
        logic init;
        logic step;
    } merge_ctl_t;

    function automatic res_row_t sat_add_row(input res_row_t a, input res_row_t b);
        logic [RES_W:0] s;
        res_row_t       r;
        for (int t = 0; t < NRES; t++) begin
            s    = {1'b0, a[t]} + {1'b0, b[t]};
            r[t] = s[RES_W] ? {RES_W{1'b1}} : s[RES_W-1:0];
        end
        return r;
    endfunction

    function automatic res_row_t sub_row(input res_row_t a, input res_row_t b);
        res_row_t r;
        for (int t = 0; t < NRES; t++) begin
            r[t] = a[t] - b[t];
        end
        return r;
    endfunction

    // true if any element of a exceeds the matching element of b
    function automatic logic any_gt(input res_row_t a, input res_row_t b);
        logic g;
        g = 1'b0;
        for (int t = 0; t < NRES; t++) begin
            if (a[t] > b[t]) begin
                g = 1'b1;
            end
        end
        return g;
    endfunction

endpackage

// ----- design/bsa_lane.sv -----
// bsa_lane: one customer's allocation and need rows plus its fit test.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_lane
    import bsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sel,
    input  row_wr_t  wr,
    input  res_row_t work,
    input  logic     done,
    output res_row_t alloc,
    output res_row_t need,
    output logic     fit
);

    res_row_t alloc_reg;
    res_row_t need_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
            need_reg  <= '0;
        end
        else if (sel && wr.en)
        begin
            alloc_reg <= wr.alloc;
            need_reg  <= wr.need;
        end
    end

    assign alloc = alloc_reg;
    assign need  = need_reg;
    assign fit   = !done && !any_gt(need_reg, work);

endmodule

// ----- design/bsa_merge.sv -----
// bsa_merge: picks the lowest fitting lane, folds its allocation into the work pool
// and tracks finished customers. Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_merge
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS = CUSTOMERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  merge_ctl_t           ctl,
    input  res_row_t             init_work,
    input  logic [CUSTOMERS-1:0] fit,
    input  res_row_t             alloc_rows [CUSTOMERS],
    output res_row_t             work,
    output logic [CUSTOMERS-1:0] done,
    output logic                 found,
    output logic                 all_done
);

    res_row_t             work_reg;
    logic [CUSTOMERS-1:0] done_reg;
    logic [CUSTOMERS-1:0] pick_oh;
    res_row_t             pick_alloc;

    // isolate lowest set bit
    assign pick_oh = fit & (~fit + CUSTOMERS'(1));

    always_comb
    begin
        pick_alloc = '0;
        for (int i = 0; i < CUSTOMERS; i++) begin
            if (pick_oh[i]) begin
                pick_alloc = pick_alloc | alloc_rows[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            done_reg <= '0;
        end
        else if (ctl.init)
        begin
            work_reg <= init_work;
            done_reg <= '0;
        end
        else if (ctl.step && found)
        begin
            work_reg <= sat_add_row(work_reg, pick_alloc);
            done_reg <= done_reg | pick_oh;
        end
    end

    assign work     = work_reg;
    assign done     = done_reg;
    assign found    = |fit;
    assign all_done = &done_reg;

endmodule

// ----- design/bankers_safe_allocator.sv -----
// bankers_safe_allocator: top level, command decode, request rollback and result register.
// Depends on bsa_pkg, bsa_lane and bsa_merge.
`timescale 1ns / 1ps

// Usage:
//   A request is taken at a rising edge with start high and busy low; op, customer and
//   amount_0..amount_3 are sampled there. Each request yields one result: strobe is high
//   for exactly one cycle with status and free_0..free_3 (available counts after the
//   step). The receiver cannot stall; the result is gone after that cycle.
// Sequencing:
//   Set, load, release and refused requests: strobe is registered from the EXEC state.
//   Granted-path requests run the safety scan, one customer retired per cycle, and the
//   strobe is registered once no lane fits any more. busy drops in the strobe cycle,
//   so the next request can be taken while the result is shown.
//   The scan length is set by the single work-pool accumulator in the merge stage; every
//   customer lane tests its need against the pool in parallel each cycle.
// Reset:
//   rst_n low clears available counts, all allocation and need rows and the control
//   state; no result is pending afterward.

module bankers_safe_allocator
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS = CUSTOMERS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [2:0] customer,
    input  logic [7:0] amount_0,
    input  logic [7:0] amount_1,
    input  logic [7:0] amount_2,
    input  logic [7:0] amount_3,
    output logic       strobe,
    output logic [2:0] status,
    output logic [7:0] free_0,
    output logic [7:0] free_1,
    output logic [7:0] free_2,
    output logic [7:0] free_3
);

    localparam int CW = $clog2(CUSTOMERS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t   state_reg, state_next;
    logic     strobe_reg, strobe_next;
    status_t  status_reg, status_next;
    res_row_t avail_reg, avail_next;

    logic [1:0] op_reg;
    logic [2:0] cust_reg;
    res_row_t   amt_reg;
    res_row_t   snap_alloc_reg, snap_need_reg;
    logic       snap_en;

    row_wr_t              row_wr;
    merge_ctl_t           mctl;
    res_row_t             init_work;
    logic [CUSTOMERS-1:0] lane_sel;
    logic [CUSTOMERS-1:0] lane_fit;
    res_row_t             lane_alloc [CUSTOMERS];
    res_row_t             lane_need  [CUSTOMERS];
    res_row_t             work;
    logic [CUSTOMERS-1:0] done_vec;
    logic                 found;
    logic                 all_done;

    logic     cust_ok;
    logic     [CW-1:0] idx;
    res_row_t sel_alloc, sel_need;

    assign cust_ok   = ({29'd0, cust_reg} < 32'(CUSTOMERS));
    assign idx       = CW'(cust_reg);
    assign sel_alloc = lane_alloc[idx];
    assign sel_need  = lane_need[idx];
    assign init_work = sub_row(avail_reg, amt_reg);

    for (genvar i = 0; i < CUSTOMERS; i++) begin : g_lane
        assign lane_sel[i] = cust_ok && ({29'd0, cust_reg} == 32'(i));

        bsa_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .sel   (lane_sel[i]),
            .wr    (row_wr),
            .work  (work),
            .done  (done_vec[i]),
            .alloc (lane_alloc[i]),
            .need  (lane_need[i]),
            .fit   (lane_fit[i])
        );
    end

    bsa_merge #(
        .CUSTOMERS (CUSTOMERS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mctl),
        .init_work  (init_work),
        .fit        (lane_fit),
        .alloc_rows (lane_alloc),
        .work       (work),
        .done       (done_vec),
        .found      (found),
        .all_done   (all_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        avail_next  = avail_reg;
        row_wr      = '0;
        mctl        = '0;
        snap_en     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_IDLE;
                strobe_next = 1'b1;
                status_next = ST_DONE;
                if (op_t'(op_reg) == OP_SET)
                begin
                    avail_next = amt_reg;
                end
                else if (cust_ok)
                begin
                    unique case (op_t'(op_reg))
                        OP_SET:
                        begin
                            avail_next = amt_reg;
                        end
                        OP_LOAD:
                        begin
                            row_wr.en    = 1'b1;
                            row_wr.alloc = '0;
                            row_wr.need  = amt_reg;
                        end
                        OP_REQ:
                        begin
                            priority if (any_gt(amt_reg, sel_need))
                            begin
                                status_next = ST_NEED;
                            end
                            else if (any_gt(amt_reg, avail_reg))
                            begin
                                status_next = ST_AVAIL;
                            end
                            else
                            begin
                                // tentative grant; scan decides keep or roll back
                                strobe_next  = 1'b0;
                                state_next   = S_SCAN;
                                snap_en      = 1'b1;
                                row_wr.en    = 1'b1;
                                row_wr.alloc = sat_add_row(sel_alloc, amt_reg);
                                row_wr.need  = sub_row(sel_need, amt_reg);
                                avail_next   = init_work;
                                mctl.init    = 1'b1;
                            end
                        end
                        OP_REL:
                        begin
                            if (any_gt(amt_reg, sel_alloc))
                            begin
                                status_next = ST_REL;
                            end
                            else
                            begin
                                row_wr.en    = 1'b1;
                                row_wr.alloc = sub_row(sel_alloc, amt_reg);
                                row_wr.need  = sat_add_row(sel_need, amt_reg);
                                avail_next   = sat_add_row(avail_reg, amt_reg);
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    mctl.step = 1'b1;
                end
                else
                begin
                    state_next  = S_IDLE;
                    strobe_next = 1'b1;
                    if (all_done)
                    begin
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        // available was reduced without wrap, so adding back is exact
                        status_next  = ST_UNSAFE;
                        row_wr.en    = 1'b1;
                        row_wr.alloc = snap_alloc_reg;
                        row_wr.need  = snap_need_reg;
                        avail_next   = sat_add_row(avail_reg, amt_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            status_reg <= ST_DONE;
            avail_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            avail_reg  <= avail_next;
        end
    end

    // request payload and rollback snapshot
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= op;
            cust_reg <= customer;
            amt_reg  <= {amount_3, amount_2, amount_1, amount_0};
        end
        if (snap_en)
        begin
            snap_alloc_reg <= sel_alloc;
            snap_need_reg  <= sel_need;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign free_0 = avail_reg[0];
    assign free_1 = avail_reg[1];
    assign free_2 = avail_reg[2];
    assign free_3 = avail_reg[3];

endmodule
